// ===== design/kvlp_pkg.sv =====
package kvlp_pkg;

  // characters the parser reacts to
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_US  = 8'h5F;

  // tdata / tuser widths on the ports
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_TUSER_W = 2;

  // result queue depth
  localparam int unsigned QUEUE_DEPTH = 3;

  // parser phase
  typedef enum logic [2:0] {
    PH_KEY,
    PH_VALUE,
    PH_PCT1,
    PH_PCT2,
    PH_DONE
  } phase_t;

  // message status codes
  typedef enum logic [2:0] {
    ST_RUN,
    ST_OK,
    ST_MISS_EQ,
    ST_BAD_KEY,
    ST_BAD_ENC
  } status_t;

  // one result item
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       in_value;
    logic       field_end;
    status_t    status;
    logic       last;
  } kvlp_res_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] num;
    kvlp_res_t  r0;
    kvlp_res_t  r1;
  } kvlp_push_t;

  // build a result with last cleared
  function automatic kvlp_res_t mk_res(logic has, logic [7:0] b, logic inval, logic fe,
                                       status_t st);
    kvlp_res_t r;
    r.has_byte  = has;
    r.out_byte  = b;
    r.in_value  = inval;
    r.field_end = fe;
    r.status    = st;
    r.last      = 1'b0;
    return r;
  endfunction

  // hex digit decode: bit 4 set when valid
  function automatic logic [4:0] hex_nib(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // allowed key characters: A-Z a-z 0-9 _
  function automatic logic is_key_char(logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_US);
  endfunction

endpackage

// ===== design/kvlp_parse.sv =====
module kvlp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              kind,
  input  logic [7:0]        data_byte,
  output kvlp_pkg::kvlp_push_t push
);
  import kvlp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       key_ne_r, key_ne_nxt;
  logic       key_bad_r, key_bad_nxt;
  logic       cr_r, cr_nxt;
  logic [3:0] hn_r, hn_nxt;
  status_t    fin_r, fin_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_KEY;
      key_ne_r  <= 1'b0;
      key_bad_r <= 1'b0;
      cr_r      <= 1'b0;
      hn_r      <= 4'h0;
      fin_r     <= ST_RUN;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      key_ne_r  <= key_ne_nxt;
      key_bad_r <= key_bad_nxt;
      cr_r      <= cr_nxt;
      hn_r      <= hn_nxt;
      fin_r     <= fin_nxt;
    end
  end

  // one byte step: optional held CR result, then at most one main result
  always_comb begin
    logic       pre;
    logic       main;
    kvlp_res_t  main_res;
    logic [4:0] nib;
    logic       ne_v;
    logic       bad_v;

    phase_nxt   = phase_r;
    key_ne_nxt  = key_ne_r;
    key_bad_nxt = key_bad_r;
    cr_nxt      = cr_r;
    hn_nxt      = hn_r;
    fin_nxt     = fin_r;
    pre         = 1'b0;
    main        = 1'b0;
    main_res    = mk_res(1'b0, 8'h00, 1'b0, 1'b0, ST_RUN);
    nib         = hex_nib(data_byte);
    ne_v        = key_ne_r;
    bad_v       = key_bad_r;

    if (kind) begin
      // end of body: report, then back to reset state
      main = 1'b1;
      case (phase_r)
        PH_DONE:  main_res = mk_res(1'b0, 8'h00, 1'b0, 1'b0, fin_r);
        PH_KEY:   main_res = mk_res(1'b0, 8'h00, 1'b0, 1'b0,
                                    key_ne_r ? ST_MISS_EQ : ST_OK);
        PH_VALUE: main_res = mk_res(1'b0, 8'h00, 1'b0, 1'b1, ST_OK);
        default:  main_res = mk_res(1'b0, 8'h00, 1'b0, 1'b0, ST_BAD_ENC);
      endcase
      phase_nxt   = PH_KEY;
      key_ne_nxt  = 1'b0;
      key_bad_nxt = 1'b0;
      cr_nxt      = 1'b0;
      hn_nxt      = 4'h0;
      fin_nxt     = ST_RUN;
    end else begin
      case (phase_r)
        PH_KEY: begin
          // held CR not followed by LF becomes a key byte
          if (cr_r && data_byte != CH_LF) begin
            pre   = 1'b1;
            ne_v  = 1'b1;
            bad_v = 1'b1;
          end
          cr_nxt      = 1'b0;
          key_ne_nxt  = ne_v;
          key_bad_nxt = bad_v;
          if (data_byte == CH_LF) begin
            main      = 1'b1;
            phase_nxt = PH_DONE;
            fin_nxt   = ne_v ? ST_MISS_EQ : ST_OK;
            main_res  = mk_res(1'b0, 8'h00, 1'b0, 1'b0, fin_nxt);
          end else if (data_byte == CH_CR) begin
            cr_nxt = 1'b1;
          end else if (data_byte == CH_EQ) begin
            if (!ne_v || bad_v) begin
              main      = 1'b1;
              phase_nxt = PH_DONE;
              fin_nxt   = ST_BAD_KEY;
              main_res  = mk_res(1'b0, 8'h00, 1'b0, 1'b0, ST_BAD_KEY);
            end else begin
              phase_nxt = PH_VALUE;
            end
          end else begin
            main        = 1'b1;
            key_ne_nxt  = 1'b1;
            key_bad_nxt = bad_v | ~is_key_char(data_byte);
            main_res    = mk_res(1'b1, data_byte, 1'b0, 1'b0, ST_RUN);
          end
        end
        PH_VALUE: begin
          // held CR not followed by LF becomes a value byte
          pre    = cr_r && (data_byte != CH_LF);
          cr_nxt = 1'b0;
          if (data_byte == CH_LF) begin
            main        = 1'b1;
            phase_nxt   = PH_KEY;
            key_ne_nxt  = 1'b0;
            key_bad_nxt = 1'b0;
            hn_nxt      = 4'h0;
            main_res    = mk_res(1'b0, 8'h00, 1'b0, 1'b1, ST_RUN);
          end else if (data_byte == CH_CR) begin
            cr_nxt = 1'b1;
          end else if (data_byte == CH_PCT) begin
            phase_nxt = PH_PCT1;
          end else begin
            main     = 1'b1;
            main_res = mk_res(1'b1, data_byte, 1'b1, 1'b0, ST_RUN);
          end
        end
        PH_PCT1, PH_PCT2: begin
          if (!nib[4]) begin
            main      = 1'b1;
            phase_nxt = PH_DONE;
            fin_nxt   = ST_BAD_ENC;
            main_res  = mk_res(1'b0, 8'h00, 1'b0, 1'b0, ST_BAD_ENC);
          end else if (phase_r == PH_PCT1) begin
            hn_nxt    = nib[3:0];
            phase_nxt = PH_PCT2;
          end else begin
            main      = 1'b1;
            phase_nxt = PH_VALUE;
            main_res  = mk_res(1'b1, {hn_r, nib[3:0]}, 1'b1, 1'b0, ST_RUN);
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end

    // pack results, mark the last one
    push.num = acc ? ({1'b0, pre} + {1'b0, main}) : 2'd0;
    push.r0  = pre ? mk_res(1'b1, CH_CR, phase_r == PH_VALUE, 1'b0, ST_RUN) : main_res;
    push.r1  = main_res;
    if (pre && main) begin
      push.r1.last = 1'b1;
    end else begin
      push.r0.last = 1'b1;
    end
  end

  // end of body always yields exactly one final result
  a_eob_one: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind |-> push.num == 2'd1 && push.r0.last)
    else $error("end of body must give one result");

  // nothing comes out once the message is finished
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !kind && phase_r == PH_DONE |-> push.num == 2'd0)
    else $error("byte after completion produced a result");

  // a pair of results always starts with the held CR
  a_pair_cr: assert property (@(posedge clk) disable iff (!rst_n)
    push.num == 2'd2 |-> push.r0.has_byte && push.r0.out_byte == CH_CR)
    else $error("two results without a held CR");

endmodule

// ===== design/kvlp_outq.sv =====
module kvlp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kvlp_pkg::kvlp_push_t push,
  output logic                 room,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output kvlp_pkg::kvlp_res_t  head
);
  import kvlp_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  kvlp_res_t         q_r [QUEUE_DEPTH];
  kvlp_res_t         q_nxt [QUEUE_DEPTH];
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign head       = q_r[0];
  // room for two results, independent of the output side this cycle
  assign room       = (cnt_r <= CW'(QUEUE_DEPTH - 2));

  // shift out the head, append new results behind what remains
  always_comb begin
    logic [CW-1:0] keep;
    keep = cnt_r - CW'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i + 1 < QUEUE_DEPTH) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (CW'(i) == keep && push.num != 2'd0) begin
        q_nxt[i] = push.r0;
      end else if (CW'(i) == keep + CW'(1) && push.num == 2'd2) begin
        q_nxt[i] = push.r1;
      end
    end
    cnt_nxt = keep + CW'(push.num);
  end

  // count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // pushes only land when two slots were free
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> cnt_r <= CW'(QUEUE_DEPTH - 2))
    else $error("result queue overflow");

endmodule

// ===== design/kv_line_parser_percent_decode.sv =====
// channel  dir  tdata                                    tuser                  tlast
// in_      in   [7:0] data_byte                          [0] kind               -
// out_     out  [7:0] out_byte [8] field_end             [0] has_byte           last
//               [11:9] status [15:12] zero               [1] in_value
//
// one input item per cycle while in_tready is high; each item is decoded in a
// single pass into zero, one or two result items, written to a three-entry
// result queue. an item that yields two results (held CR plus current byte)
// fills two queue slots; input ready needs two free queue slots.
// rst_n is synchronous, active low; parser returns to key phase, queue empties.
// a stall on out_ fills the queue and then holds in_tready low.
module kv_line_parser_percent_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kvlp_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                                in_tuser,   // [0] kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kvlp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [7:0] out_byte, [8] field_end,
                                                          // [11:9] status
  output logic [kvlp_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [0] has_byte, [1] in_value
  output logic                                out_tlast
);
  import kvlp_pkg::*;

  logic       acc;
  kvlp_push_t push;
  kvlp_res_t  head;

  assign acc = in_tvalid && in_tready;

  // single-pass decoder with parser state
  kvlp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .kind      (in_tuser),
    .data_byte (in_tdata[7:0]),
    .push      (push)
  );

  // result queue
  kvlp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  // output packing
  assign out_tdata = {4'h0, head.status, head.field_end, head.out_byte};
  assign out_tuser = {head.in_value, head.has_byte};
  assign out_tlast = head.last;

endmodule

// ===== tb/tb_kv_line_parser_percent_decode.sv =====
module tb_kv_line_parser_percent_decode;
  timeunit 1ns;
  timeprecision 1ps;

  import kvlp_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 9;
  localparam int ITEM_TARGET  = 1550;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 50;

  // expected result tracker with its own copy of the parser state
  class kv_scoreboard;
    phase_t     ph;
    bit         key_seen;
    bit         key_bad;
    bit         cr_held;
    logic [3:0] hi_nib;
    status_t    fin_st;
    kvlp_res_t  batch[$];
    kvlp_res_t  exp_q[$];
    int unsigned errors;

    function new();
      start_line();
      fin_st = ST_RUN;
      errors = 0;
    endfunction

    function void start_line();
      ph       = PH_KEY;
      key_seen = 1'b0;
      key_bad  = 1'b0;
      cr_held  = 1'b0;
      hi_nib   = 4'h0;
    endfunction

    function int hex_digit_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function bit key_char_ok(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z") || c == CH_US;
    endfunction

    function void add(logic has, logic [7:0] b, logic inval, logic fe, status_t st);
      kvlp_res_t r;
      r.has_byte  = has;
      r.out_byte  = b;
      r.in_value  = inval;
      r.field_end = fe;
      r.status    = st;
      r.last      = 1'b0;
      batch = {batch, r};
    endfunction

    // message ends here: remember why and report it
    function void close(status_t st);
      ph     = PH_DONE;
      fin_st = st;
      add(1'b0, 8'h00, 1'b0, 1'b0, st);
    endfunction

    function void key_step(logic [7:0] b);
      if (b == CH_LF) begin
        close(key_seen ? ST_MISS_EQ : ST_OK);
      end else if (b == CH_CR) begin
        cr_held = 1'b1;
      end else if (b == CH_EQ) begin
        if (!key_seen || key_bad) close(ST_BAD_KEY);
        else ph = PH_VALUE;
      end else begin
        key_seen = 1'b1;
        if (!key_char_ok(b)) key_bad = 1'b1;
        add(1'b1, b, 1'b0, 1'b0, ST_RUN);
      end
    endfunction

    function void value_step(logic [7:0] b);
      if (cr_held) begin
        cr_held = 1'b0;
        if (b != CH_LF) add(1'b1, CH_CR, 1'b1, 1'b0, ST_RUN);
      end
      if (b == CH_LF) begin
        start_line();
        add(1'b0, 8'h00, 1'b0, 1'b1, ST_RUN);
      end else if (b == CH_CR) begin
        cr_held = 1'b1;
      end else if (b == CH_PCT) begin
        ph = PH_PCT1;
      end else begin
        add(1'b1, b, 1'b1, 1'b0, ST_RUN);
      end
    endfunction

    // work out the results of one accepted input item
    function void note_item(logic kind, logic [7:0] b);
      int h;
      status_t st;
      logic fe;
      if (kind) begin
        fe = 1'b0;
        case (ph)
          PH_DONE:  st = fin_st;
          PH_KEY:   st = key_seen ? ST_MISS_EQ : ST_OK;
          PH_VALUE: begin
            st = ST_OK;
            fe = 1'b1;
          end
          default:  st = ST_BAD_ENC;
        endcase
        add(1'b0, 8'h00, 1'b0, fe, st);
        start_line();
        fin_st = ST_RUN;
      end else begin
        h = hex_digit_val(b);
        case (ph)
          PH_KEY: begin
            if (cr_held) begin
              cr_held = 1'b0;
              if (b == CH_LF) begin
                close(key_seen ? ST_MISS_EQ : ST_OK);
              end else begin
                // held cr is not a line end: it becomes a bad key byte
                key_seen = 1'b1;
                key_bad  = 1'b1;
                add(1'b1, CH_CR, 1'b0, 1'b0, ST_RUN);
                key_step(b);
              end
            end else begin
              key_step(b);
            end
          end
          PH_VALUE: value_step(b);
          PH_PCT1: begin
            if (h < 0) begin
              close(ST_BAD_ENC);
            end else begin
              hi_nib = h[3:0];
              ph     = PH_PCT2;
            end
          end
          PH_PCT2: begin
            if (h < 0) begin
              close(ST_BAD_ENC);
            end else begin
              ph = PH_VALUE;
              add(1'b1, {hi_nib, h[3:0]}, 1'b1, 1'b0, ST_RUN);
            end
          end
          default: ph = PH_DONE;
        endcase
      end
      if (batch.size() > 0) begin
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) exp_q = {exp_q, batch[i]};
        batch.delete();
      end
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(kvlp_res_t got, logic [3:0] pad);
      kvlp_res_t want;
      if (exp_q.size() == 0) begin
        $error("result item with nothing expected: byte %0d status %0d",
               got.out_byte, got.status);
        errors++;
        return;
      end
      want = exp_q.pop_front();
      compare("has_byte", want.has_byte, got.has_byte);
      compare("out_byte", want.out_byte, got.out_byte);
      compare("in_value", want.in_value, got.in_value);
      compare("field_end", want.field_end, got.field_end);
      compare("status", int'(want.status), int'(got.status));
      compare("last", want.last, got.last);
      compare("tdata_pad", 0, pad);
    endfunction

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                    in_tuser   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;  // [7:0] out_byte, [8] field_end, [11:9] status
  logic [OUT_TUSER_W-1:0]  out_tuser;  // [0] has_byte, [1] in_value
  logic                    out_tlast;

  kv_scoreboard sb = new();
  int burst_left = 0;
  int sent = 0;

  kv_line_parser_percent_decode uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // offer one item, with bursts and gaps between them
  task automatic send_item(input logic kind, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(kind, b);
    burst_left--;
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_eob();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] rand_key_char();
    int k;
    k = $urandom_range(0, 62);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 36) return 8'h41 + 8'(k - 10);
    if (k < 62) return 8'h61 + 8'(k - 36);
    return CH_US;
  endfunction

  function automatic logic [7:0] rand_plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_LF || b == CH_CR || b == CH_PCT) b = "v";
    return b;
  endfunction

  task automatic send_line_end();
    if ($urandom_range(0, 1)) send_item(1'b0, CH_CR);
    send_item(1'b0, CH_LF);
  endtask

  // mostly well-formed messages with random content, the rest noise
  task automatic send_message();
    int n_lines, klen, vlen, r;
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) begin
      n_lines = $urandom_range(0, 4);
      repeat (n_lines) begin
        klen = $urandom_range(1, 6);
        repeat (klen) begin
          if ($urandom_range(0, 24) == 0) send_item(1'b0, rand_plain_byte());
          else send_item(1'b0, rand_key_char());
        end
        send_item(1'b0, CH_EQ);
        vlen = $urandom_range(0, 8);
        repeat (vlen) begin
          r = $urandom_range(0, 39);
          if (r < 10) begin
            b = 8'($urandom_range(0, 255));
            send_item(1'b0, CH_PCT);
            send_item(1'b0, hex_char(b[7:4], 1'($urandom_range(0, 1))));
            send_item(1'b0, hex_char(b[3:0], 1'($urandom_range(0, 1))));
          end else if (r == 10) begin
            // broken escape
            send_item(1'b0, CH_PCT);
            send_item(1'b0, 8'($urandom_range(0, 255)));
          end else if (r == 11) begin
            send_item(1'b0, CH_CR);
            send_item(1'b0, rand_plain_byte());
          end else begin
            send_item(1'b0, rand_plain_byte());
          end
        end
        send_line_end();
      end
      if ($urandom_range(0, 2) != 0) begin
        send_line_end();
        repeat ($urandom_range(0, 3)) send_item(1'b0, 8'($urandom_range(0, 255)));
      end
      send_eob();
    end else begin
      repeat ($urandom_range(1, 12)) begin
        r = $urandom_range(0, 7);
        case (r)
          0:       send_item(1'b0, CH_LF);
          1:       send_item(1'b0, CH_CR);
          2:       send_item(1'b0, CH_EQ);
          3:       send_item(1'b0, CH_PCT);
          4:       send_item(1'b0, hex_char(4'($urandom_range(0, 15)),
                                            1'($urandom_range(0, 1))));
          default: send_item(1'b0, 8'($urandom_range(0, 255)));
        endcase
      end
      send_eob();
    end
  endtask

  // stimulus and end of run
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key chars, escapes in both cases, crlf ending a field, blank crlf line
    send_text("a_Z9=%4a%fF\015\n\015\n");
    // byte after completion is ignored, end of body repeats the status
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'hFF);
    // held cr before a byte, then a bad key caught at '='
    send_text("k\015");
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CH_EQ);
    send_eob();
    // empty key
    send_text("=");
    send_eob();

    while (sent < ITEM_TARGET) send_message();
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: changing stall patterns plus one long hold-off
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    kvlp_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.has_byte  = out_tuser[0];
      got.out_byte  = out_tdata[7:0];
      got.in_value  = out_tuser[1];
      got.field_end = out_tdata[8];
      got.status    = status_t'(out_tdata[11:9]);
      got.last      = out_tlast;
      sb.check_result(got, out_tdata[15:12]);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/kvlp_pkg.sv
design/kvlp_parse.sv
design/kvlp_outq.sv
design/kv_line_parser_percent_decode.sv
tb/tb_kv_line_parser_percent_decode.sv
